### design/jts_pkg.sv
// shared types and event codes of the json token scanner
`timescale 1ns / 1ps

package jts_pkg;

  localparam int MaxRes = 3;

  typedef enum logic [3:0] {
    EvStrByte  = 4'd0,
    EvNumByte  = 4'd1,
    EvObjBegin = 4'd2,
    EvObjEnd   = 4'd3,
    EvArrBegin = 4'd4,
    EvArrEnd   = 4'd5,
    EvStrDone  = 4'd6,
    EvKeyDone  = 4'd7,
    EvNumDone  = 4'd8,
    EvDocDone  = 4'd9,
    EvBad      = 4'd10,
    EvEof      = 4'd11,
    EvDepth    = 4'd12
  } event_e;

  typedef struct packed {
    event_e     ev;
    logic [7:0] data;
    logic [7:0] depth;
    logic       nl;
  } res_t;

  typedef struct packed {
    logic [1:0]             cnt;
    res_t [MaxRes-1:0]      res;
  } bundle_t;

endpackage

### design/jts_front.sv
// byte scanner: per-byte state update and event bundle generation
`timescale 1ns / 1ps

module jts_front import jts_pkg::*; #(
  parameter int MaxDepth = 255
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_input_i,
  output logic       push_o,
  output bundle_t    bundle_o
);

  localparam logic [7:0] DepthLimit = (MaxDepth > 255) ? 8'd255 : 8'(MaxDepth);

  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChColon  = 8'h3A;
  localparam logic [7:0] ChLbrack = 8'h5B;
  localparam logic [7:0] ChRbrack = 8'h5D;
  localparam logic [7:0] ChLbrace = 8'h7B;
  localparam logic [7:0] ChRbrace = 8'h7D;
  localparam logic [7:0] ChMinus  = 8'h2D;
  localparam logic [7:0] ChPlus   = 8'h2B;
  localparam logic [7:0] ChDot    = 8'h2E;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] ChLowA   = 8'h61;
  localparam logic [7:0] ChLowZ   = 8'h7A;
  localparam logic [7:0] ChUpA    = 8'h41;
  localparam logic [7:0] ChUpE    = 8'h45;
  localparam logic [7:0] ChLowE   = 8'h65;
  localparam logic [7:0] ChLowB   = 8'h62;
  localparam logic [7:0] ChLowF   = 8'h66;
  localparam logic [7:0] ChLowN   = 8'h6E;
  localparam logic [7:0] ChLowR   = 8'h72;
  localparam logic [7:0] ChLowT   = 8'h74;
  localparam logic [7:0] ChLowU   = 8'h75;

  typedef enum logic [2:0] {
    MIdle, MStr, MEsc, MHex, MColon, MNum, MDone, MErr
  } mode_e;

  function automatic res_t mk_res(event_e ev, logic [7:0] data, logic [7:0] dep, logic nl);
    res_t r;
    r.ev    = ev;
    r.data  = data;
    r.depth = dep;
    r.nl    = nl;
    return r;
  endfunction

  mode_e       mode_q, mode_d;
  logic [15:0] acc_q, acc_d;
  logic [1:0]  hcnt_q, hcnt_d;
  logic [7:0]  dep_q, dep_d;
  logic        nl_q, nl_d;

  res_t [MaxRes-1:0] res_v;
  logic [1:0]        n_v;
  logic              do_idle;
  logic [7:0]        c;
  logic [7:0]        up;
  logic [15:0]       hex_n;
  logic              is_digit;
  logic              is_ws;

  assign c        = in_byte_i;
  assign is_digit = (c >= ChZero) && (c <= ChNine);
  assign is_ws    = (c == ChSpace) || ((c >= ChTab) && (c <= ChCr));
  assign up       = ((c >= ChLowA) && (c <= ChLowZ)) ? c - 8'd32 : c;
  assign hex_n    = is_digit ? {12'd0, c[3:0]} : {8'd0, up} + 16'd10 - {8'd0, ChUpA};

  always_comb begin
    mode_d  = mode_q;
    acc_d   = acc_q;
    hcnt_d  = hcnt_q;
    dep_d   = dep_q;
    nl_d    = nl_q;
    res_v   = '0;
    n_v     = 2'd0;
    do_idle = 1'b0;
    if (mode_q != MDone && mode_q != MErr) begin
      if (end_of_input_i) begin
        if (mode_q == MNum) begin
          res_v[n_v] = mk_res(EvNumDone, 8'd0, dep_q, nl_q);
          n_v = n_v + 2'd1;
          nl_d = 1'b0;
          if (dep_q == 8'd0) begin
            res_v[n_v] = mk_res(EvDocDone, 8'd0, dep_q, 1'b0);
            mode_d = MDone;
          end else begin
            res_v[n_v] = mk_res(EvEof, 8'd0, dep_q, 1'b0);
            mode_d = MErr;
          end
          n_v = n_v + 2'd1;
        end else begin
          res_v[n_v] = mk_res(EvEof, 8'd0, dep_q, nl_q);
          n_v = n_v + 2'd1;
          mode_d = MErr;
        end
      end else begin
        unique case (mode_q)
          MStr: begin
            if (c == ChBslash) begin
              mode_d = MEsc;
            end else if (c == ChQuote) begin
              mode_d = MColon;
            end else begin
              res_v[n_v] = mk_res(EvStrByte, c, dep_q, nl_q);
              n_v = n_v + 2'd1;
            end
          end
          MEsc: begin
            mode_d = MStr;
            res_v[n_v] = mk_res(EvStrByte, c, dep_q, nl_q);
            n_v = n_v + 2'd1;
            case (c)
              ChLowB: res_v[0].data = 8'h08;
              ChLowF: res_v[0].data = 8'h0C;
              ChLowN: res_v[0].data = 8'h0A;
              ChLowR: res_v[0].data = 8'h0D;
              ChLowT: res_v[0].data = 8'h09;
              ChLowU: begin
                n_v    = 2'd0;
                res_v  = '0;
                acc_d  = 16'd0;
                hcnt_d = 2'd0;
                mode_d = MHex;
              end
              default: ;
            endcase
          end
          MHex: begin
            acc_d = {acc_q[11:0], 4'h0} + hex_n;
            if (hcnt_q == 2'd3) begin
              hcnt_d = 2'd0;
              mode_d = MStr;
              if (acc_d < 16'h0080) begin
                res_v[0] = mk_res(EvStrByte, acc_d[7:0], dep_q, nl_q);
                n_v = 2'd1;
              end else if (acc_d < 16'h0800) begin
                res_v[0] = mk_res(EvStrByte, {3'b110, acc_d[10:6]}, dep_q, nl_q);
                res_v[1] = mk_res(EvStrByte, {2'b10, acc_d[5:0]}, dep_q, nl_q);
                n_v = 2'd2;
              end else begin
                res_v[0] = mk_res(EvStrByte, {4'hE, acc_d[15:12]}, dep_q, nl_q);
                res_v[1] = mk_res(EvStrByte, {2'b10, acc_d[11:6]}, dep_q, nl_q);
                res_v[2] = mk_res(EvStrByte, {2'b10, acc_d[5:0]}, dep_q, nl_q);
                n_v = 2'd3;
              end
            end else begin
              hcnt_d = hcnt_q + 2'd1;
            end
          end
          MColon: begin
            if (!is_ws) begin
              res_v[0] = mk_res((c == ChColon) ? EvKeyDone : EvStrDone, 8'd0, dep_q, nl_q);
              n_v  = 2'd1;
              nl_d = 1'b0;
              if (dep_q == 8'd0) begin
                res_v[1] = mk_res(EvDocDone, 8'd0, dep_q, 1'b0);
                n_v = 2'd2;
                mode_d = MDone;
              end else begin
                mode_d  = MIdle;
                do_idle = (c != ChColon);
              end
            end
          end
          MNum: begin
            if (is_digit || c == ChPlus || c == ChMinus || c == ChLowE ||
                c == ChUpE || c == ChDot) begin
              res_v[0] = mk_res(EvNumByte, c, dep_q, nl_q);
              n_v = 2'd1;
            end else begin
              res_v[0] = mk_res(EvNumDone, 8'd0, dep_q, nl_q);
              n_v  = 2'd1;
              nl_d = 1'b0;
              if (dep_q == 8'd0) begin
                res_v[1] = mk_res(EvDocDone, 8'd0, dep_q, 1'b0);
                n_v = 2'd2;
                mode_d = MDone;
              end else begin
                mode_d  = MIdle;
                do_idle = 1'b1;
              end
            end
          end
          default: begin
            mode_d  = MIdle;
            do_idle = 1'b1;
          end
        endcase
        if (do_idle) begin
          case (c)
            ChLf: nl_d = 1'b1;
            ChSpace, ChTab, ChCr, ChComma: ;
            ChLbrack, ChLbrace: begin
              if (dep_d >= DepthLimit) begin
                res_v[n_v] = mk_res(EvDepth, 8'd0, dep_d, nl_d);
                mode_d = MErr;
              end else begin
                dep_d = dep_d + 8'd1;
                res_v[n_v] = mk_res((c == ChLbrack) ? EvArrBegin : EvObjBegin,
                                    8'd0, dep_d, nl_d);
                nl_d = 1'b0;
              end
              n_v = n_v + 2'd1;
            end
            ChRbrack, ChRbrace: begin
              if (dep_d == 8'd0) begin
                res_v[n_v] = mk_res(EvBad, 8'd0, dep_d, nl_d);
                n_v = n_v + 2'd1;
                mode_d = MErr;
              end else begin
                dep_d = dep_d - 8'd1;
                res_v[n_v] = mk_res((c == ChRbrack) ? EvArrEnd : EvObjEnd,
                                    8'd0, dep_d, nl_d);
                n_v = n_v + 2'd1;
                nl_d = 1'b0;
                if (dep_d == 8'd0) begin
                  res_v[n_v] = mk_res(EvDocDone, 8'd0, dep_d, 1'b0);
                  n_v = n_v + 2'd1;
                  mode_d = MDone;
                end
              end
            end
            ChQuote: mode_d = MStr;
            default: begin
              if (is_digit || c == ChMinus) begin
                res_v[n_v] = mk_res(EvNumByte, c, dep_d, nl_d);
                mode_d = MNum;
              end else begin
                res_v[n_v] = mk_res(EvBad, 8'd0, dep_d, nl_d);
                mode_d = MErr;
              end
              n_v = n_v + 2'd1;
            end
          endcase
        end
      end
    end
  end

  assign push_o       = accept_i && (n_v != 2'd0);
  assign bundle_o.cnt = n_v;
  assign bundle_o.res = res_v;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MIdle;
      acc_q  <= 16'd0;
      hcnt_q <= 2'd0;
      dep_q  <= 8'd0;
      nl_q   <= 1'b0;
    end else if (accept_i) begin
      mode_q <= mode_d;
      acc_q  <= acc_d;
      hcnt_q <= hcnt_d;
      dep_q  <= dep_d;
      nl_q   <= nl_d;
    end
  end

  // a finished or failed document never produces events again
  a_silent_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MDone || mode_q == MErr) |-> !push_o)
    else $error("events after end of document");

  a_depth_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dep_q <= DepthLimit)
    else $error("nesting depth above limit");

  a_error_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(mode_q == MErr) |-> mode_q == MErr)
    else $error("error state left");

endmodule

### design/jts_queue.sv
// two-entry queue of event bundles between scanner and output stage
`timescale 1ns / 1ps

module jts_queue import jts_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  bundle_t push_data_i,
  output logic    full_o,
  input  logic    pop_i,
  output logic    empty_o,
  output bundle_t head_o
);

  bundle_t    mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty queue");

  a_no_empty_bundle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> push_data_i.cnt != 2'd0)
    else $error("empty bundle queued");

endmodule

### design/jts_back.sv
// output stage: walks each bundle and presents one event per transfer
`timescale 1ns / 1ps

module jts_back import jts_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       empty_i,
  input  bundle_t    head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [3:0] event_res_o,
  output logic [7:0] data_byte_o,
  output logic [7:0] nest_depth_o,
  output logic       newline_before_o,
  output logic       last_o
);

  logic       load;
  logic       take;
  logic       is_last;
  logic [1:0] slot_q;
  logic       valid_q;
  res_t       res_q;
  logic       last_q;

  assign load    = !valid_q || out_ready_i;
  assign take    = load && !empty_i;
  assign is_last = (slot_q == head_i.cnt - 2'd1);
  assign pop_o   = take && is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      slot_q  <= 2'd0;
    end else begin
      if (load) valid_q <= !empty_i;
      if (take) slot_q  <= is_last ? 2'd0 : slot_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q  <= head_i.res[slot_q];
      last_q <= is_last;
    end
  end

  assign out_valid_o      = valid_q;
  assign event_res_o      = res_q.ev;
  assign data_byte_o      = res_q.data;
  assign nest_depth_o     = res_q.depth;
  assign newline_before_o = res_q.nl;
  assign last_o           = last_q;

  a_slot_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_i |-> slot_q < head_i.cnt)
    else $error("slot beyond bundle");

  a_last_after_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (out_valid_o && last_o))
    else $error("bundle popped without last event");

  a_slot_reset_on_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> slot_q == 2'd0)
    else $error("slot not rewound");

endmodule

### design/json_token_scanner.sv
// top level of the streaming json token scanner
`timescale 1ns / 1ps

// Streaming JSON tokenizer. One text byte is taken per cycle whenever the two-entry
// event queue has room; each byte yields zero to three token events, which leave one
// per output transfer. Bytes that cause no event (whitespace, quotes, escape starts)
// never occupy the output, so the sustained rate is one byte per cycle until the
// output port, at one event per cycle, becomes the limit. First event of a byte is
// written to the event queue as the byte is taken, then to the output register. After
// docdone or an error the block keeps accepting bytes and drops them until reset.
module json_token_scanner import jts_pkg::*; #(
  parameter int MAX_DEPTH = 255
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_input_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [3:0] event_res_o,
  output logic [7:0] data_byte_o,
  output logic [7:0] nest_depth_o,
  output logic       newline_before_o,
  output logic       last_o
);

  logic    accept;
  logic    push;
  bundle_t push_bundle;
  logic    full;
  logic    empty;
  logic    pop;
  bundle_t head;

  assign in_ready_o = !full;
  assign accept     = in_valid_i && in_ready_o;

  jts_front #(
    .MaxDepth(MAX_DEPTH)
  ) u_front (
    .clk_i,
    .rst_ni,
    .accept_i      (accept),
    .in_byte_i,
    .end_of_input_i,
    .push_o        (push),
    .bundle_o      (push_bundle)
  );

  jts_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i      (push),
    .push_data_i (push_bundle),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .head_o      (head)
  );

  jts_back u_back (
    .clk_i,
    .rst_ni,
    .empty_i          (empty),
    .head_i           (head),
    .pop_o            (pop),
    .out_valid_o,
    .out_ready_i,
    .event_res_o,
    .data_byte_o,
    .nest_depth_o,
    .newline_before_o,
    .last_o
  );

endmodule

### tb/sv/json_token_scanner_test.sv
// self-checking testbench of the json token scanner: byte stream driver, event predictor, checker
`timescale 1ns / 1ps

module json_token_scanner_test;
  import jts_pkg::*;

  localparam int MaxDepth = 255;
  localparam logic [7:0] DepthLimit = (MaxDepth > 255) ? 8'd255 : 8'(MaxDepth);
  localparam int RandomBytes = 215;
  localparam int WatchdogLimit = 4000;
  localparam int TailCycles = 20;
  localparam int PhaseBytes = 50;
  localparam int SendIdlePct [4] = '{0, 63, 0, 22};
  localparam int RecvStallPct [4] = '{0, 0, 63, 22};
  localparam int MaxEventsPerByte = 4;

  localparam logic [7:0] ChTab = 8'h09;
  localparam logic [7:0] ChLf = 8'h0A;
  localparam logic [7:0] ChCr = 8'h0D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChLbrack = 8'h5B;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChRbrack = 8'h5D;
  localparam logic [7:0] ChLbrace = 8'h7B;
  localparam logic [7:0] ChRbrace = 8'h7D;

  typedef enum logic [2:0] {
    ModeIdle, ModeStr, ModeEsc, ModeHex, ModeColon, ModeNum, ModeDone, ModeErr
  } scan_mode_e;

  typedef struct packed {
    logic [7:0] value;
    logic       eoi;
  } text_item_t;

  typedef struct {
    event_e     ev;
    logic [7:0] data;
    logic [7:0] depth;
    logic       nl;
    logic       last;
  } token_event_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic [7:0] in_byte_i = 8'h00;
  logic       end_of_input_i = 1'b0;
  logic       out_ready_i = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [3:0] event_res_o;
  logic [7:0] data_byte_o;
  logic [7:0] nest_depth_o;
  logic       newline_before_o;
  logic       last_o;

  json_token_scanner #(.MAX_DEPTH(MaxDepth)) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .in_byte_i        (in_byte_i),
    .end_of_input_i   (end_of_input_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .event_res_o      (event_res_o),
    .data_byte_o      (data_byte_o),
    .nest_depth_o     (nest_depth_o),
    .newline_before_o (newline_before_o),
    .last_o           (last_o)
  );

  text_item_t   text_bytes[$];
  text_item_t   cur_item = '0;
  text_item_t   taken_item = '0;
  logic         taken_valid = 1'b0;
  int           bytes_taken = 0;
  int           total_items = 0;
  int           mismatches = 0;
  int           stall_cycles = 0;
  logic [1:0]   idle_phase;
  token_event_t token_events_due[$];
  token_event_t byte_events[$];

  assign idle_phase = 2'((bytes_taken / PhaseBytes) % 4);

  // scanner state as the block should hold it
  scan_mode_e sc_mode = ModeIdle;
  logic [15:0] sc_hex = '0;
  logic [1:0]  sc_hex_n = '0;
  logic [7:0]  sc_depth = '0;
  logic        sc_nl = 1'b0;
  logic        sc_seen = 1'b0;

  function automatic void post_event(event_e ev, logic [7:0] d);
    token_event_t e;
    e.ev = ev;
    e.data = d;
    e.depth = sc_depth;
    e.nl = sc_nl;
    e.last = 1'b0;
    if (byte_events.size() < MaxEventsPerByte)
      byte_events.insert(byte_events.size(), e);
  endfunction

  function automatic void raise_error(event_e ev);
    post_event(ev, 8'h00);
    sc_mode = ModeErr;
  endfunction

  function automatic void close_token(event_e ev);
    post_event(ev, 8'h00);
    sc_nl = 1'b0;
    sc_seen = 1'b1;
    if (sc_depth == 8'd0) begin
      post_event(EvDocDone, 8'h00);
      sc_mode = ModeDone;
    end else begin
      sc_mode = ModeIdle;
    end
  endfunction

  function automatic bit num_char(logic [7:0] c);
    return (c >= "0" && c <= "9") || c == "+" || c == ChMinus || c == "e" || c == "E" ||
           c == ".";
  endfunction

  function automatic void scan_between(logic [7:0] c);
    case (c)
      ChLf: sc_nl = 1'b1;
      ChSpace, ChTab, ChCr, ChComma: ;
      ChLbrack, ChLbrace: begin
        if (sc_depth >= DepthLimit) begin
          raise_error(EvDepth);
        end else begin
          sc_depth = sc_depth + 8'd1;
          close_token((c == ChLbrack) ? EvArrBegin : EvObjBegin);
        end
      end
      ChRbrack, ChRbrace: begin
        if (sc_depth == 8'd0) begin
          raise_error(EvBad);
        end else begin
          sc_depth = sc_depth - 8'd1;
          close_token((c == ChRbrack) ? EvArrEnd : EvObjEnd);
        end
      end
      ChQuote: sc_mode = ModeStr;
      default: begin
        if (c == ChMinus || (c >= "0" && c <= "9")) begin
          sc_mode = ModeNum;
          post_event(EvNumByte, c);
        end else begin
          raise_error(EvBad);
        end
      end
    endcase
  endfunction

  function automatic void put_utf8(logic [15:0] code);
    if (code < 16'h0080) begin
      post_event(EvStrByte, code[7:0]);
    end else if (code < 16'h0800) begin
      post_event(EvStrByte, {3'b110, code[10:6]});
      post_event(EvStrByte, {2'b10, code[5:0]});
    end else begin
      post_event(EvStrByte, {4'b1110, code[15:12]});
      post_event(EvStrByte, {2'b10, code[11:6]});
      post_event(EvStrByte, {2'b10, code[5:0]});
    end
  endfunction

  function automatic void scan_text_byte(logic [7:0] c, logic eoi);
    logic [15:0] nib;
    logic [7:0]  up;
    byte_events.delete();
    if (sc_mode == ModeDone || sc_mode == ModeErr) return;
    if (eoi) begin
      if (sc_mode == ModeNum) begin
        close_token(EvNumDone);
        if (sc_mode != ModeDone) raise_error(EvEof);
      end else begin
        raise_error(EvEof);
      end
    end else begin
      case (sc_mode)
        ModeStr: begin
          if (c == ChBslash) sc_mode = ModeEsc;
          else if (c == ChQuote) sc_mode = ModeColon;
          else post_event(EvStrByte, c);
        end
        ModeEsc: begin
          sc_mode = ModeStr;
          case (c)
            "b": post_event(EvStrByte, 8'h08);
            "f": post_event(EvStrByte, 8'h0C);
            "n": post_event(EvStrByte, 8'h0A);
            "r": post_event(EvStrByte, 8'h0D);
            "t": post_event(EvStrByte, 8'h09);
            "u": begin
              sc_hex = '0;
              sc_hex_n = '0;
              sc_mode = ModeHex;
            end
            default: post_event(EvStrByte, c);
          endcase
        end
        ModeHex: begin
          if (c >= "0" && c <= "9") begin
            nib = {8'h00, c - 8'h30};
          end else begin
            up = (c >= "a" && c <= "z") ? c - 8'd32 : c;
            nib = 16'd10 + {8'h00, up} - 16'h0041;
          end
          sc_hex = {sc_hex[11:0], 4'h0} + nib;
          if (sc_hex_n == 2'd3) begin
            put_utf8(sc_hex);
            sc_hex_n = '0;
            sc_mode = ModeStr;
          end else begin
            sc_hex_n = sc_hex_n + 2'd1;
          end
        end
        ModeColon: begin
          if (c == ChSpace || (c >= ChTab && c <= ChCr)) begin
            // lf while looking for a colon is not remembered
          end else if (c == ChColon) begin
            close_token(EvKeyDone);
          end else begin
            close_token(EvStrDone);
            if (sc_mode == ModeIdle) scan_between(c);
          end
        end
        ModeNum: begin
          if (num_char(c)) begin
            post_event(EvNumByte, c);
          end else begin
            close_token(EvNumDone);
            if (sc_mode == ModeIdle) scan_between(c);
          end
        end
        default: begin
          sc_mode = ModeIdle;
          scan_between(c);
        end
      endcase
    end
    if (byte_events.size() != 0) byte_events[byte_events.size() - 1].last = 1'b1;
    foreach (byte_events[i]) token_events_due.insert(token_events_due.size(), byte_events[i]);
  endfunction

  // text generation
  function automatic void put_byte(logic [7:0] b);
    text_item_t t;
    t.value = b;
    t.eoi = 1'b0;
    text_bytes.insert(text_bytes.size(), t);
  endfunction

  function automatic void put_end();
    text_item_t t;
    t.value = 8'($urandom_range(0, 255));
    t.eoi = 1'b1;
    text_bytes.insert(text_bytes.size(), t);
  endfunction

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endfunction

  function automatic logic [7:0] pick(string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  function automatic void gen_gap(bit need);
    int n;
    n = need ? $urandom_range(1, 3) : $urandom_range(0, 2);
    repeat (n) put_byte(pick(" \t\r\n,"));
  endfunction

  function automatic void gen_hex4();
    logic [15:0] code;
    logic [3:0]  nib;
    case ($urandom_range(0, 3))
      0: code = 16'h0000;
      1: code = 16'($urandom_range(1, 16'h007F));
      2: code = 16'($urandom_range(16'h0080, 16'h07FF));
      default: code = 16'($urandom_range(16'h0800, 16'hFFFF));
    endcase
    for (int i = 3; i >= 0; i--) begin
      nib = code[4*i +: 4];
      if ($urandom_range(0, 9) == 0) put_byte(8'($urandom_range(0, 255)));
      else if (nib < 4'd10) put_byte(8'h30 + {4'h0, nib});
      else if ($urandom_range(0, 1) == 0) put_byte(8'h41 + {4'h0, nib} - 8'd10);
      else put_byte(8'h61 + {4'h0, nib} - 8'd10);
    end
  endfunction

  function automatic void gen_string();
    int n;
    int k;
    logic [7:0] b;
    put_byte(ChQuote);
    n = $urandom_range(0, 6);
    repeat (n) begin
      k = $urandom_range(0, 9);
      if (k < 6) begin
        b = 8'($urandom_range(0, 255));
        if (b == ChQuote || b == ChBslash) b = b ^ 8'h01;
        put_byte(b);
      end else if (k < 8) begin
        put_byte(ChBslash);
        b = ($urandom_range(0, 1) == 0) ? pick("bfnrt") : 8'($urandom_range(0, 255));
        if (b == "u") b = "v";
        put_byte(b);
      end else begin
        put_byte(ChBslash);
        put_byte("u");
        gen_hex4();
      end
    end
    put_byte(ChQuote);
  endfunction

  function automatic void gen_key();
    gen_string();
    repeat ($urandom_range(0, 2)) put_byte(pick(" \t\n\r\013\014"));
    put_byte(ChColon);
  endfunction

  function automatic void gen_number();
    put_byte(($urandom_range(0, 3) == 0) ? ChMinus : pick("0123456789"));
    repeat ($urandom_range(0, 4)) put_byte(pick("0123456789+-eE."));
  endfunction

  function automatic bit idle_ok(logic [7:0] b);
    return (b >= "0" && b <= "9") || b == ChSpace || b == ChTab || b == ChCr || b == ChLf ||
           b == ChComma || b == ChLbrack || b == ChRbrack || b == ChLbrace ||
           b == ChRbrace || b == ChQuote || b == ChMinus;
  endfunction

  // nested values inside the top-level array, kept well formed bar mismatched closers
  function automatic void gen_values(int target);
    bit open_obj[$];
    logic [7:0] closer;
    while (text_bytes.size() < target || open_obj.size() != 0) begin
      if (open_obj.size() != 0 &&
          ($urandom_range(0, 3) == 0 || text_bytes.size() >= target)) begin
        gen_gap(0);
        closer = open_obj[$] ? ChRbrace : ChRbrack;
        if ($urandom_range(0, 9) == 0) closer = open_obj[$] ? ChRbrack : ChRbrace;
        put_byte(closer);
        void'(open_obj.pop_back());
      end else begin
        gen_gap(1);
        if (open_obj.size() != 0 && open_obj[$]) begin
          gen_key();
          gen_gap(0);
        end
        case ($urandom_range(0, 5))
          0, 1: gen_string();
          2: gen_number();
          default: begin
            if (open_obj.size() >= 3) begin
              gen_string();
            end else if ($urandom_range(0, 1) == 0) begin
              put_byte(ChLbrace);
              open_obj.insert(open_obj.size(), 1'b1);
            end else begin
              put_byte(ChLbrack);
              open_obj.insert(open_obj.size(), 1'b0);
            end
          end
        endcase
      end
    end
  endfunction

  function automatic void check_field(string what, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      mismatches++;
    end
  endfunction

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;
  end

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      taken_valid <= in_valid_i && in_ready_o;
      taken_item <= cur_item;
      if (in_valid_i && in_ready_o) bytes_taken <= bytes_taken + 1;
      if (!in_valid_i || in_ready_o) begin
        if (text_bytes.size() != 0 && $urandom_range(0, 99) >= SendIdlePct[idle_phase]) begin
          cur_item = text_bytes.pop_front();
          in_valid_i <= 1'b1;
          in_byte_i <= cur_item.value;
          end_of_input_i <= cur_item.eoi;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: predict the byte taken at the previous edge, then check the event transfer
  always @(posedge clk_i) begin
    token_event_t want;
    if (rst_ni) begin
      if (taken_valid) scan_text_byte(taken_item.value, taken_item.eoi);
      if (out_valid_o && out_ready_i) begin
        if (token_events_due.size() == 0) begin
          $display("%0t: event mismatch, expected none, actual event %0d data %0h depth %0d",
                   $time, event_res_o, data_byte_o, nest_depth_o);
          mismatches++;
        end else begin
          want = token_events_due.pop_front();
          check_field("event", {4'h0, want.ev}, {4'h0, event_res_o});
          check_field("data", want.data, data_byte_o);
          check_field("depth", want.depth, nest_depth_o);
          check_field("newline", {7'h00, want.nl}, {7'h00, newline_before_o});
          check_field("last", {7'h00, want.last}, {7'h00, last_o});
        end
      end
      out_ready_i <= ($urandom_range(0, 99) >= RecvStallPct[idle_phase]);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= WatchdogLimit) begin
        $display("%0t: no transfer for %0d cycles", $time, stall_cycles);
        $display("CHECKS FAILED");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    logic [7:0] b;
    int ending;
    // leading newline, object with key, lf before colon, number ended by a closer,
    // three-byte utf-8 escape, unknown escape, number right after a string
    put_text(" \n[{\"k\"\n:-1E5}\"\\u20ac\\q\"7,");
    ending = $urandom_range(0, 5);
    // the depth run is long enough on its own
    gen_values(text_bytes.size() + ((ending == 4) ? 0 : RandomBytes));
    case (ending)
      0: begin
        gen_gap(0);
        put_byte(ChLf);
        put_byte(ChRbrack);
      end
      1: begin
        gen_gap(1);
        put_end();
      end
      2: begin
        put_byte(ChComma);
        gen_number();
        put_end();
      end
      3: begin
        gen_gap(1);
        b = 8'($urandom_range(0, 255));
        if (idle_ok(b)) b = ChColon;
        put_byte(b);
      end
      4: begin
        // open up to the depth limit, then one more
        gen_gap(1);
        repeat (int'(DepthLimit)) put_byte(pick("[{"));
      end
      default: begin
        gen_gap(1);
        put_byte(ChQuote);
        put_byte("x");
        put_end();
      end
    endcase
    repeat ($urandom_range(1, 4)) put_byte(8'($urandom_range(0, 255)));
    put_end();
    total_items = text_bytes.size();

    while (bytes_taken < total_items || taken_valid || token_events_due.size() != 0)
      @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### files.f
design/jts_pkg.sv
design/jts_front.sv
design/jts_queue.sv
design/jts_back.sv
design/json_token_scanner.sv
tb/sv/json_token_scanner_test.sv
